FILE: src/assert_macros.svh
// Assertion macros used by the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// generic clocked assertion with an active-low reset
`define CC_ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("cc20 property violated");

// assertion on the block clock and reset
`define CC_ASSERT(lbl, prop) `CC_ASSERT_CLK(lbl, i_clk, i_rst_n, prop)

`endif

FILE: src/cc20_pkg.sv
// Types, constants and the state setup function of the ChaCha20 keystream block.
// No dependencies.
`timescale 1ns / 1ps

package cc20_pkg;

    localparam logic [31:0] SIGMA0 = 32'h6170_7865;
    localparam logic [31:0] SIGMA1 = 32'h3320_646e;
    localparam logic [31:0] SIGMA2 = 32'h7962_2d32;
    localparam logic [31:0] SIGMA3 = 32'h6b20_6574;

    localparam int DOUBLE_ROUNDS = 10;
    localparam int STEPS         = 8 * DOUBLE_ROUNDS;
    localparam int STEP_W        = $clog2(STEPS);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(STEPS - 1);

    localparam logic [3:0] MAX_BLOCKS = 4'd8;
    localparam int FIFO_DEPTH = 2;
    localparam int ADDR_W     = 6;
    localparam int DATA_W     = 64;

    localparam logic [2:0] REG_KEY0   = 3'd0;
    localparam logic [2:0] REG_KEY1   = 3'd1;
    localparam logic [2:0] REG_KEY2   = 3'd2;
    localparam logic [2:0] REG_KEY3   = 3'd3;
    localparam logic [2:0] REG_NONCE0 = 3'd4;
    localparam logic [2:0] REG_NONCE1 = 3'd5;

    typedef logic [15:0][31:0] t_state;
    typedef logic [3:0][63:0]  t_key;

    typedef struct packed {
        logic [31:0] ctr;
        logic [2:0]  offset;
        logic        last;
    } t_job;

    typedef struct packed {
        t_state     words;
        logic [2:0] offset;
        logic       last;
    } t_blk;

    function automatic t_state cc20_init(input t_key key, input logic [63:0] nonce0,
                                         input logic [31:0] nonce1,
                                         input logic [31:0] ctr);
        t_state s;
        s[0] = SIGMA0;
        s[1] = SIGMA1;
        s[2] = SIGMA2;
        s[3] = SIGMA3;
        for (int i = 0; i < 4; i++) begin
            s[4 + 2 * i] = key[i][31:0];
            s[5 + 2 * i] = key[i][63:32];
        end
        s[12] = ctr;
        s[13] = nonce0[31:0];
        s[14] = nonce0[63:32];
        s[15] = nonce1;
        return s;
    endfunction

endpackage

FILE: src/cc20_front.sv
// Request front end: takes a request and splits it into one job per block.
// Depends on cc20_pkg.
`timescale 1ns / 1ps

module cc20_front import cc20_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_start_counter,
    input  logic [3:0]  i_block_count,
    input  logic        i_full,
    output logic        o_busy,
    output logic        o_push,
    output t_job        o_job
);

    logic [3:0]  r_rem;
    logic [31:0] r_ctr;
    logic [2:0]  r_off;
    logic [3:0]  n_rem;

    assign o_busy = (r_rem != 4'd0);
    assign o_push = o_busy && !i_full;
    assign n_rem  = (i_block_count > MAX_BLOCKS) ? MAX_BLOCKS : i_block_count;

    assign o_job.ctr    = r_ctr;
    assign o_job.offset = r_off;
    assign o_job.last   = (r_rem == 4'd1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem <= 4'd0;
        end else if (i_start && !o_busy) begin
            r_rem <= n_rem;
            r_ctr <= i_start_counter;
            r_off <= 3'd0;
        end else if (o_push) begin
            r_rem <= r_rem - 4'd1;
            r_ctr <= r_ctr + 32'd1;
            r_off <= r_off + 3'd1;
        end
    end

endmodule

FILE: src/cc20_queue.sv
// Short job queue between the front end and the round engine.
// Depends on cc20_pkg.
`timescale 1ns / 1ps

module cc20_queue import cc20_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output logic o_full,
    output logic o_empty,
    output t_job o_head
);

    localparam int AW = $clog2(FIFO_DEPTH);
    localparam int CW = $clog2(FIFO_DEPTH + 1);

    t_job          r_mem [FIFO_DEPTH];
    logic [AW-1:0] r_wp;
    logic [AW-1:0] r_rp;
    logic [CW-1:0] r_cnt;
    logic          w_push;
    logic          w_pop;

    assign o_full  = (r_cnt == CW'(FIFO_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rp];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= (r_wp == AW'(FIFO_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= (r_rp == AW'(FIFO_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + CW'(w_push) - CW'(w_pop);
        end
    end

endmodule

FILE: src/cc20_core.sv
// Round engine: one quarter-round step on all four lanes per cycle, then feed-forward.
// Depends on cc20_pkg.
`timescale 1ns / 1ps

module cc20_core import cc20_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_key        i_key,
    input  logic [63:0] i_nonce0,
    input  logic [31:0] i_nonce1,
    input  logic        i_empty,
    input  t_job        i_head,
    output logic        o_pop,
    input  logic        i_out_rdy,
    output logic        o_blk_valid,
    output t_blk        o_blk
);

    typedef enum logic [1:0] {S_IDLE, S_ROUND, S_ADD, S_DONE} t_cstate;

    t_cstate           r_state;
    t_state            r_x;
    t_state            n_x;
    t_state            w_init;
    logic [31:0]       r_ctr;
    logic [2:0]        r_off;
    logic              r_last;
    logic [STEP_W-1:0] r_step;
    logic              w_diag;
    logic [1:0]        w_phase;

    assign w_diag  = r_step[2];
    assign w_phase = r_step[1:0];
    assign w_init  = cc20_init(i_key, i_nonce0, i_nonce1, r_ctr);

    assign o_pop        = (r_state == S_IDLE) && !i_empty;
    assign o_blk_valid  = (r_state == S_DONE);
    assign o_blk.words  = r_x;
    assign o_blk.offset = r_off;
    assign o_blk.last   = r_last;

    always_comb begin
        logic [31:0] a, b, c, d, sum, mix, rot;
        n_x = r_x;
        for (int q = 0; q < 4; q++) begin
            a = r_x[q];
            b = w_diag ? r_x[4 + ((q + 1) & 3)]  : r_x[4 + q];
            c = w_diag ? r_x[8 + ((q + 2) & 3)]  : r_x[8 + q];
            d = w_diag ? r_x[12 + ((q + 3) & 3)] : r_x[12 + q];
            sum = w_phase[0] ? (c + d) : (a + b);
            mix = w_phase[0] ? (b ^ sum) : (d ^ sum);
            case (w_phase)
                2'd0:    rot = {mix[15:0], mix[31:16]};
                2'd1:    rot = {mix[19:0], mix[31:20]};
                2'd2:    rot = {mix[23:0], mix[31:24]};
                default: rot = {mix[24:0], mix[31:25]};
            endcase
            if (!w_phase[0]) begin
                n_x[q] = sum;
                if (w_diag) begin
                    n_x[12 + ((q + 3) & 3)] = rot;
                end else begin
                    n_x[12 + q] = rot;
                end
            end else begin
                if (w_diag) begin
                    n_x[8 + ((q + 2) & 3)] = sum;
                    n_x[4 + ((q + 1) & 3)] = rot;
                end else begin
                    n_x[8 + q] = sum;
                    n_x[4 + q] = rot;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        r_x     <= cc20_init(i_key, i_nonce0, i_nonce1, i_head.ctr);
                        r_ctr   <= i_head.ctr;
                        r_off   <= i_head.offset;
                        r_last  <= i_head.last;
                        r_step  <= '0;
                        r_state <= S_ROUND;
                    end
                end
                S_ROUND: begin
                    r_x    <= n_x;
                    r_step <= r_step + 1'b1;
                    if (r_step == LAST_STEP) begin
                        r_state <= S_ADD;
                    end
                end
                S_ADD: begin
                    for (int i = 0; i < 16; i++) begin
                        r_x[i] <= r_x[i] + w_init[i];
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (i_out_rdy) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

FILE: src/cc20_outbuf.sv
// Output buffer: holds one finished block and shifts it out as eight 64-bit words.
// Depends on cc20_pkg.
`timescale 1ns / 1ps

module cc20_outbuf import cc20_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_blk_valid,
    input  t_blk        i_blk,
    output logic        o_rdy,
    output logic        o_valid,
    output logic [63:0] o_keystream_word,
    output logic [2:0]  o_block_offset,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);

    logic [63:0] r_buf [8];
    logic [2:0]  r_cnt;
    logic        r_active;
    logic [2:0]  r_off;
    logic        r_last;

    assign o_rdy = !r_active || (r_cnt == 3'd7);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_cnt       <= 3'd0;
            o_valid     <= 1'b0;
            o_last_word <= 1'b0;
        end else begin
            o_valid     <= r_active;
            o_last_word <= r_active && r_last && (r_cnt == 3'd7);
            if (r_active) begin
                o_keystream_word <= r_buf[0];
                o_word_index     <= r_cnt;
                o_block_offset   <= r_off;
            end
            if (i_blk_valid && o_rdy) begin
                for (int w = 0; w < 8; w++) begin
                    r_buf[w] <= {i_blk.words[2 * w + 1], i_blk.words[2 * w]};
                end
                r_off    <= i_blk.offset;
                r_last   <= i_blk.last;
                r_cnt    <= 3'd0;
                r_active <= 1'b1;
            end else if (r_active) begin
                for (int i = 0; i < 7; i++) begin
                    r_buf[i] <= r_buf[i + 1];
                end
                r_cnt <= r_cnt + 3'd1;
                if (r_cnt == 3'd7) begin
                    r_active <= 1'b0;
                end
            end
        end
    end

endmodule

FILE: src/chacha20_keystream_blocks.sv
// Top level of the ChaCha20 keystream generator: registers, front end, queue, engine, output.
// Depends on cc20_pkg, cc20_front, cc20_queue, cc20_core, cc20_outbuf.
//
//  channel   | handshake                     | payload
//  ----------+-------------------------------+--------------------------------------------
//  request   | start, busy                   | i_start_counter, i_block_count
//  result    | o_valid                       | o_keystream_word, o_block_offset,
//            |                               | o_word_index, o_last_word
//  config    | psel, penable, pwrite, pready | paddr, pwdata, prdata
//
// Each block passes through the round engine as load, 80 quarter-round steps, feed-forward and
// handoff; the handoff waits until the output buffer can take the block.
// The eight output words of a block shift out while the engine computes the next block.
// busy is high while jobs of the request remain to be queued; reset is synchronous, active low.
// Results are never held off by the receiver.
`timescale 1ns / 1ps

module chacha20_keystream_blocks import cc20_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [31:0]       i_start_counter,
    input  logic [3:0]        i_block_count,
    output logic              o_valid,
    output logic [63:0]       o_keystream_word,
    output logic [2:0]        o_block_offset,
    output logic [2:0]        o_word_index,
    output logic              o_last_word,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    t_key        r_key;
    logic [63:0] r_nonce0;
    logic [31:0] r_nonce1;
    logic [2:0]  w_idx;
    logic        w_wr;

    logic        w_push;
    t_job        w_job;
    logic        w_full;
    logic        w_empty;
    t_job        w_head;
    logic        w_pop;
    logic        w_out_rdy;
    logic        w_blk_valid;
    t_blk        w_blk;

    assign pready = 1'b1;
    assign w_idx  = paddr[ADDR_W-1:3];
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key    <= '0;
            r_nonce0 <= '0;
            r_nonce1 <= '0;
        end else if (w_wr) begin
            case (w_idx)
                REG_KEY0:   r_key[0] <= pwdata;
                REG_KEY1:   r_key[1] <= pwdata;
                REG_KEY2:   r_key[2] <= pwdata;
                REG_KEY3:   r_key[3] <= pwdata;
                REG_NONCE0: r_nonce0 <= pwdata;
                REG_NONCE1: r_nonce1 <= pwdata[31:0];
                default:    ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_KEY0:   prdata = r_key[0];
            REG_KEY1:   prdata = r_key[1];
            REG_KEY2:   prdata = r_key[2];
            REG_KEY3:   prdata = r_key[3];
            REG_NONCE0: prdata = r_nonce0;
            REG_NONCE1: prdata = {32'd0, r_nonce1};
            default:    prdata = '0;
        endcase
    end

    cc20_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .i_start_counter (i_start_counter),
        .i_block_count   (i_block_count),
        .i_full          (w_full),
        .o_busy          (busy),
        .o_push          (w_push),
        .o_job           (w_job)
    );

    cc20_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_head  (w_head)
    );

    cc20_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_key       (r_key),
        .i_nonce0    (r_nonce0),
        .i_nonce1    (r_nonce1),
        .i_empty     (w_empty),
        .i_head      (w_head),
        .o_pop       (w_pop),
        .i_out_rdy   (w_out_rdy),
        .o_blk_valid (w_blk_valid),
        .o_blk       (w_blk)
    );

    cc20_outbuf u_outbuf (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_blk_valid      (w_blk_valid),
        .i_blk            (w_blk),
        .o_rdy            (w_out_rdy),
        .o_valid          (o_valid),
        .o_keystream_word (o_keystream_word),
        .o_block_offset   (o_block_offset),
        .o_word_index     (o_word_index),
        .o_last_word      (o_last_word)
    );

endmodule

FILE: src/cc20_checker.sv
// Port-level checks on the ChaCha20 keystream generator, bound to the top level.
// Depends on assert_macros.svh and chacha20_keystream_blocks.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cc20_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic [3:0] i_block_count,
    input logic       o_valid,
    input logic [2:0] o_block_offset,
    input logic [2:0] o_word_index,
    input logic       o_last_word
);

    // words of a block leave back to back, in order
    `CC_ASSERT(a_words_in_order, o_valid && o_word_index != 3'd7 |=> o_valid && o_word_index == $past(o_word_index) + 3'd1)
    `CC_ASSERT(a_offset_steady, o_valid && o_word_index != 3'd7 |=> $stable(o_block_offset))
    `CC_ASSERT(a_last_on_word7, o_last_word |-> o_valid && o_word_index == 3'd7)
    `CC_ASSERT(a_busy_after_start, start && !busy && i_block_count != 4'd0 |=> busy)

endmodule

bind chacha20_keystream_blocks cc20_checker u_cc20_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .i_block_count  (i_block_count),
    .o_valid        (o_valid),
    .o_block_offset (o_block_offset),
    .o_word_index   (o_word_index),
    .o_last_word    (o_last_word)
);
